/* hw/rtl/exp_pitch_sine_oscillator_core_assert.svh */
// assertion macros for the oscillator core
`ifndef EXP_PITCH_SINE_OSCILLATOR_CORE_ASSERT_SVH
`define EXP_PITCH_SINE_OSCILLATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define EPSO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("epso assertion failed");

// next-cycle implication, disabled in reset
`define EPSO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("epso assertion failed");

`else

`define EPSO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define EPSO_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/epso_pkg.sv */
// shared types, constants and lookup tables of the oscillator core
`timescale 1ns / 1ps

package epso_pkg;

    // table sizes
    localparam int EXP_TABLE_BITS  = 8;
    localparam int SINE_TABLE_BITS = 10;
    localparam int EXP_N           = 1 << EXP_TABLE_BITS;
    localparam int SIN_N           = 1 << SINE_TABLE_BITS;
    localparam int EXP_ADDR_W      = EXP_TABLE_BITS + 1;
    localparam int SIN_ADDR_W      = SINE_TABLE_BITS + 1;
    localparam int R_BITS          = 12 - EXP_TABLE_BITS;

    // field and register widths
    localparam int CV_W     = 16;
    localparam int KNOB_W   = 13;
    localparam int PERIOD_W = 25;
    localparam int SINE_W   = 15;
    localparam int MAG_W    = 14;
    localparam int PHASE_W  = 32;
    localparam int EXP_W    = 32;
    localparam int MUL_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 25;

    // arithmetic constants
    localparam logic [31:0] C4_Q16     = 32'd17145895;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
    localparam int          AMP_Q12    = 10240;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 25'd89478;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KNOB_PITCH    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 8'd1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_INTERP,
        S_EXSUM,
        S_BASE,
        S_PERIOD,
        S_PHASE,
        S_SINE,
        S_OUT
    } t_state;

    // operand selection of the shared multiplier
    typedef enum logic [1:0] {
        MOP_INTERP,
        MOP_BASE,
        MOP_INC
    } t_mul_op;

    // control from sequencer to datapath
    typedef struct packed {
        t_state  state;
        logic    busy;
        logic    ld_look;
        logic    ld_exsum;
        t_mul_op mul_op;
        logic    ld_phase;
        logic    ld_sine;
        logic    ld_out;
    } t_seq_ctl;

    typedef logic [EXP_N:0][EXP_W-1:0] t_exp_rom;
    typedef logic [SIN_N:0][MAG_W-1:0] t_sin_rom;

    // exp2 table, 2^(i/N) in unsigned Q2.30, series evaluated at elaboration
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] y;
        logic [63:0] t;
        logic [63:0] sum;
        rom = '0;
        for (int i = 0; i <= EXP_N; i++) begin
            y   = (64'(LN2_Q32) * 64'(i)) >> EXP_TABLE_BITS;
            t   = 64'h1_0000_0000;
            sum = t;
            for (int k = 1; k <= 14; k++) begin
                t   = ((t * y) >> 32) / 64'(k);
                sum = sum + t;
            end
            rom[i] = EXP_W'((sum + 64'd2) >> 2);
        end
        return rom;
    endfunction

    // quarter-wave sine table scaled to 2.5 V in Q.12
    function automatic t_sin_rom build_sin_rom();
        t_sin_rom           rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic signed [63:0] v;
        rom = '0;
        for (int i = 0; i <= SIN_N; i++) begin
            x  = (64'(HALFPI_Q30) * 64'(i)) >> SINE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = x;
            s  = $signed(x);
            for (int k = 1; k <= 10; k++) begin
                t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    s = s - $signed(t);
                end else begin
                    s = s + $signed(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            v = (s * 64'sd10240 + (64'sd1 <<< 29)) >>> 30;
            if (v > 64'sd10240) begin
                v = 64'sd10240;
            end
            rom[i] = MAG_W'(v);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();
    localparam t_sin_rom SIN_ROM = build_sin_rom();

endpackage

/* hw/rtl/epso_mul.sv */
// shared 32 x 32 multiplier with registered product
`timescale 1ns / 1ps

module epso_mul
    import epso_pkg::*;
(
    input  logic                 i_clk,
    input  logic [MUL_W-1:0]     i_a,
    input  logic [MUL_W-1:0]     i_b,
    output logic [2*MUL_W-1:0]   o_p
);

    logic [2*MUL_W-1:0] r_p;

    // product register, loaded every cycle
    always_ff @(posedge i_clk) begin
        r_p <= (2*MUL_W)'(i_a) * (2*MUL_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

/* hw/rtl/epso_seq.sv */
// sequencer that steps one sample through the shared multiplier
`timescale 1ns / 1ps

module epso_seq
    import epso_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_accept,
    input  logic     i_out_free,
    output t_seq_ctl o_ctl
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK:   n_state = S_INTERP;
            S_INTERP: n_state = S_EXSUM;
            S_EXSUM:  n_state = S_BASE;
            S_BASE:   n_state = S_PERIOD;
            S_PERIOD: n_state = S_PHASE;
            S_PHASE:  n_state = S_SINE;
            S_SINE:   n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctl          = '0;
        o_ctl.state    = r_state;
        o_ctl.busy     = (r_state != S_IDLE);
        o_ctl.mul_op   = MOP_INTERP;
        unique case (r_state)
            S_LOOK:   o_ctl.ld_look  = 1'b1;
            S_INTERP: o_ctl.mul_op   = MOP_INTERP;
            S_EXSUM:  o_ctl.ld_exsum = 1'b1;
            S_BASE:   o_ctl.mul_op   = MOP_BASE;
            S_PERIOD: o_ctl.mul_op   = MOP_INC;
            S_PHASE:  o_ctl.ld_phase = 1'b1;
            S_SINE:   o_ctl.ld_sine  = 1'b1;
            S_OUT:    o_ctl.ld_out   = i_out_free;
            default:  o_ctl.mul_op   = MOP_INTERP;
        endcase
    end

endmodule

/* hw/rtl/exp_pitch_sine_oscillator_core.sv */
// top level of the volt-per-octave sine oscillator core
`timescale 1ns / 1ps
`include "exp_pitch_sine_oscillator_core_assert.svh"

// Usage
// Input channel: one signed Q4.12 pitch word on i_pitch_cv, taken at an edge
// where i_in_valid is high and o_in_stall is low. Output channel: one word of
// o_sine_out (signed Q3.12 volts) and o_light_on, taken where o_out_valid is
// high and i_out_stall is low.
// Configuration: i_cfg_index 0 writes the knob offset, 1 the sample period;
// o_cfg_ready is always high and other indexes are ignored. Write only while
// the core is idle.
// Sequence: an accepted word steps through LOOK, INTERP, EXSUM, BASE, PERIOD,
// PHASE, SINE and OUT, where the output register is loaded. The single multiplier is used three times in series
// (interpolation, base frequency, phase increment) around the exp2 and sine
// table reads, and the core stalls its input meanwhile.
// The output register lets a new word be accepted while the last result
// waits; a stalled receiver holds the core in its final step.
// Reset: synchronous, active low; both phases clear, knob offset goes to 0
// and the sample period to 89478 (48 kHz).

module exp_pitch_sine_oscillator_core
    import epso_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [CV_W-1:0]   i_pitch_cv,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [SINE_W-1:0] o_sine_out,
    output logic                     o_light_on,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_seq_ctl w_ctl;
    logic     w_in_accept;
    logic     w_out_free;

    logic [KNOB_W-1:0]   r_knob_pitch;
    logic [PERIOD_W-1:0] r_sample_period;
    logic [PHASE_W-1:0]  r_osc_phase;
    logic [PHASE_W-1:0]  r_blink_phase;

    logic [EXP_TABLE_BITS-1:0] r_idx;
    logic [R_BITS-1:0]         r_rem;
    logic [4:0]                r_shamt;
    logic [EXP_W-1:0]          r_ex_lo;
    logic [EXP_W-1:0]          r_ex_diff;
    logic [EXP_W-1:0]          r_ex;
    logic [MAG_W-1:0]          r_sine_mag;
    logic                      r_sine_neg;

    logic                      r_out_valid;
    logic signed [SINE_W-1:0]  r_sine_out;
    logic                      r_light_on;

    logic signed [17:0]  w_sum;
    logic signed [17:0]  w_clamp;
    logic [17:0]         w_q;
    logic [3:0]          w_oct;
    logic [11:0]         w_fp;
    logic [EXP_ADDR_W-1:0] w_addr_lo;
    logic [EXP_ADDR_W-1:0] w_addr_hi;
    logic [MUL_W-1:0]    w_mul_a;
    logic [MUL_W-1:0]    w_mul_b;
    logic [2*MUL_W-1:0]  w_mul_p;
    logic [PHASE_W-1:0]  w_inc;
    logic [1:0]          w_quad;
    logic [SINE_TABLE_BITS-1:0] w_sidx;
    logic [SIN_ADDR_W-1:0] w_saddr;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    epso_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl)
    );

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_knob_pitch    <= '0;
            r_sample_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KNOB_PITCH:    r_knob_pitch    <= i_cfg_data[KNOB_W-1:0];
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // pitch sum, clamp to plus or minus four octaves and split into octave and fraction
    assign w_sum   = 18'(i_pitch_cv) + $signed({5'b0, r_knob_pitch});
    assign w_clamp = (w_sum < -18'sd16384) ? -18'sd16384 :
                     (w_sum >  18'sd16384) ?  18'sd16384 : w_sum;
    assign w_q     = 18'(w_clamp + 18'sd16384);
    assign w_oct   = w_q[15:12];
    assign w_fp    = w_q[11:0];

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_idx   <= w_fp[11 -: EXP_TABLE_BITS];
            r_rem   <= w_fp[R_BITS-1:0];
            r_shamt <= 5'(5'd20 - {1'b0, w_oct});
        end
    end

    // exp2 table reads for both neighbours
    assign w_addr_lo = {1'b0, r_idx};
    assign w_addr_hi = EXP_ADDR_W'(w_addr_lo + 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_ctl.ld_look) begin
            r_ex_lo   <= EXP_ROM[w_addr_lo];
            r_ex_diff <= EXP_ROM[w_addr_hi] - EXP_ROM[w_addr_lo];
        end
        if (w_ctl.ld_exsum) begin
            r_ex <= r_ex_lo + EXP_W'(w_mul_p >> R_BITS);
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        case (w_ctl.mul_op)
            MOP_BASE: begin
                w_mul_a = C4_Q16;
                w_mul_b = r_ex;
            end
            MOP_INC: begin
                w_mul_a = w_mul_p[30 +: MUL_W];
                w_mul_b = MUL_W'(r_sample_period);
            end
            default: begin
                w_mul_a = r_ex_diff;
                w_mul_b = MUL_W'(r_rem);
            end
        endcase
    end

    epso_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // phase accumulators
    assign w_inc = PHASE_W'(w_mul_p >> r_shamt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_phase   <= '0;
            r_blink_phase <= '0;
        end else if (w_ctl.ld_phase) begin
            r_osc_phase   <= r_osc_phase + w_inc;
            r_blink_phase <= r_blink_phase + PHASE_W'(r_sample_period);
        end
    end

    // quarter-wave sine lookup
    assign w_quad  = r_osc_phase[PHASE_W-1 -: 2];
    assign w_sidx  = r_osc_phase[PHASE_W-3 -: SINE_TABLE_BITS];
    assign w_saddr = w_quad[0] ? SIN_ADDR_W'(SIN_N - int'(w_sidx))
                               : {1'b0, w_sidx};

    always_ff @(posedge i_clk) begin
        if (w_ctl.ld_sine) begin
            r_sine_mag <= SIN_ROM[w_saddr];
            r_sine_neg <= w_quad[1];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.ld_out) begin
            r_sine_out <= r_sine_neg ? -$signed({1'b0, r_sine_mag})
                                     :  $signed({1'b0, r_sine_mag});
            r_light_on <= !r_blink_phase[PHASE_W-1];
        end
    end

    assign o_in_stall  = w_ctl.busy;
    assign o_out_valid = r_out_valid;
    assign o_sine_out  = r_sine_out;
    assign o_light_on  = r_light_on;

    // checks
    `EPSO_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_accept, (w_ctl.state == S_LOOK) && o_in_stall)
    `EPSO_ASSERT_NEXT(a_blink_only_on_update, i_clk, i_rst_n, !w_ctl.ld_phase, $stable(r_blink_phase))
    `EPSO_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall, !w_ctl.ld_out)
    `EPSO_ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, (w_ctl.state == S_OUT) && w_out_free, o_out_valid)

endmodule
